@@ design/hbbc_pkg.sv @@
// ----------------------------------------------------------------------------
// hbbc_pkg: shared types and constants of the hashed block buffer cache
// Sizes, action and status codes, and the entry table access structs.
// ----------------------------------------------------------------------------
package hbbc_pkg;

	// sizes
	localparam int BUFFERS  = 32;
	localparam int BUCKETS  = 13;
	localparam int IDX_W    = $clog2(BUFFERS);
	localparam int BKT_W    = $clog2(BUCKETS + 1);
	localparam int DEV_W    = 8;
	localparam int BLK_W    = 32;
	localparam int CNT_W    = 8;
	localparam int ACT_W    = 2;
	localparam int STAT_W   = 2;
	localparam int SLOT_W   = 5;

	// scaled reciprocal of the bucket count, exact for every block number
	localparam int BKT_SHIFT = BLK_W + $clog2(BUCKETS);
	localparam logic [BLK_W:0] BKT_RECIP =
		(BLK_W+1)'(((64'd1 << BKT_SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// action codes
	localparam logic [ACT_W-1:0] ACT_READ    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PIN     = 2'd2;
	localparam logic [ACT_W-1:0] ACT_UNPIN   = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_FREE   = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [STAT_W-1:0] ST_SATURATED = 2'd3;

	// one entry as seen on the table read port
	typedef struct packed {
		logic [DEV_W-1:0] device;
		logic [BLK_W-1:0] block;
		logic [BKT_W-1:0] bucket;
		logic [CNT_W-1:0] count;
		logic             valid;
		logic [IDX_W-1:0] rank;
	} tbl_rd_t;

	// update command for the entry table
	typedef struct packed {
		logic             wr;
		logic             set_valid;
		logic             retag;
		logic             mtf;
		logic [IDX_W-1:0] idx;
		logic [CNT_W-1:0] count;
		logic [DEV_W-1:0] device;
		logic [BLK_W-1:0] block;
		logic [BKT_W-1:0] bucket;
		logic [IDX_W-1:0] old_rank;
	} tbl_wr_t;

endpackage

@@ design/hbbc_if.sv @@
// ----------------------------------------------------------------------------
// hbbc_if: request and response channels of the buffer cache
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hbbc_req_if;
	logic                           valid;
	logic                           ready;
	logic [hbbc_pkg::ACT_W-1:0]     action;
	logic [hbbc_pkg::DEV_W-1:0]     device;
	logic [hbbc_pkg::BLK_W-1:0]     block_number;
	logic [hbbc_pkg::SLOT_W-1:0]    entry_index;

	modport source (output valid, action, device, block_number, entry_index, input ready);
	modport sink (input valid, action, device, block_number, entry_index, output ready);
endinterface

interface hbbc_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [hbbc_pkg::SLOT_W-1:0]    slot;
	logic                           hit;
	logic                           need_fill;
	logic [hbbc_pkg::STAT_W-1:0]    status;
	logic [hbbc_pkg::CNT_W-1:0]     count_after;

	modport source (output valid, slot, hit, need_fill, status, count_after, input ready);
	modport sink (input valid, slot, hit, need_fill, status, count_after, output ready);
endinterface

@@ design/hashed_block_buffer_cache.sv @@
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache: tag engine of a hashed block buffer cache
// Lookup, victim choice and reference counting over a shared entry scanner.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   action, device, block_number, entry_index
//   rsp      out  valid/ready   slot, hit, need_fill, status, count_after
//
// A read scans the entries one per cycle, checking the tag and the victim
// order together (ending early on a hit), then goes to the update state.
// Release, pin and unpin go straight to the update state. One item is
// worked on at a time; req.ready is low meanwhile.
// The result register holds an item while rsp stalls and the next request is
// taken; the update cycle waits until that register is free.
// Reset clears all tags and counts and sets each entry's rank to its index.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache (
	input  logic       clk,
	input  logic       arst_n,
	hbbc_req_if.sink   req,
	hbbc_rsp_if.source rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	localparam logic [hbbc_pkg::IDX_W-1:0] LAST = hbbc_pkg::IDX_W'(hbbc_pkg::BUFFERS - 1);

	logic [1:0]                    state_q;
	logic [hbbc_pkg::ACT_W-1:0]    act_q;
	logic [hbbc_pkg::DEV_W-1:0]    dev_q;
	logic [hbbc_pkg::BLK_W-1:0]    blk_q;
	logic [hbbc_pkg::SLOT_W-1:0]   idx_q;
	logic [hbbc_pkg::IDX_W-1:0]    scan_q;
	logic                          hit_q;
	logic                          found_q;
	logic [hbbc_pkg::IDX_W-1:0]    vict_q;
	logic [hbbc_pkg::BKT_W-1:0]    best_bkt_q;
	logic [hbbc_pkg::IDX_W-1:0]    best_rank_q;

	logic                          out_valid_q;
	logic [hbbc_pkg::SLOT_W-1:0]   slot_q;
	logic                          hit_out_q;
	logic                          fill_q;
	logic [hbbc_pkg::STAT_W-1:0]   status_q;
	logic [hbbc_pkg::CNT_W-1:0]    count_q;

	logic                          accept;
	logic                          mod_done;
	logic [hbbc_pkg::BKT_W-1:0]    mod_rem;
	hbbc_pkg::tbl_rd_t             rd;
	hbbc_pkg::tbl_wr_t             wr;
	logic                          match;
	logic                          better;
	logic                          out_free;
	logic                          fin_go;

	logic [hbbc_pkg::SLOT_W-1:0]   res_slot;
	logic                          res_hit;
	logic                          res_fill;
	logic [hbbc_pkg::STAT_W-1:0]   res_status;
	logic [hbbc_pkg::CNT_W-1:0]    res_count;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	hbbc_bucket_unit u_bucket (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.value  (req.block_number),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	hbbc_entry_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (scan_q),
		.rd      (rd),
		.wr      (wr)
	);

	// scan compare: tag match and victim order (bucket, then rank)
	assign match  = (rd.device == dev_q) && (rd.block == blk_q);
	assign better = (rd.count == '0) &&
		(!found_q || ({rd.bucket, rd.rank} < {best_bkt_q, best_rank_q}));

	// the update cycle needs a free result register and, on allocation, the bucket
	assign out_free = !out_valid_q || rsp.ready;
	assign fin_go   = (state_q == S_FIN) && out_free &&
		((act_q != hbbc_pkg::ACT_READ) || hit_q || !found_q || mod_done);

	// result and table update of the final cycle
	always_comb begin
		res_slot   = '0;
		res_hit    = 1'b0;
		res_fill   = 1'b0;
		res_status = hbbc_pkg::ST_OK;
		res_count  = '0;
		wr         = '0;
		wr.device  = dev_q;
		wr.block   = blk_q;
		wr.bucket  = mod_rem;
		wr.old_rank = best_rank_q;
		if (act_q == hbbc_pkg::ACT_READ) begin
			if (hit_q) begin
				res_slot = hbbc_pkg::SLOT_W'(scan_q);
				res_hit  = 1'b1;
				res_fill = !rd.valid;
				if (rd.count == hbbc_pkg::CNT_MAX) begin
					res_status = hbbc_pkg::ST_SATURATED;
					res_count  = rd.count;
				end else begin
					res_count = rd.count + 1'b1;
				end
				wr.wr        = fin_go;
				wr.set_valid = 1'b1;
				wr.idx       = scan_q;
				wr.count     = res_count;
			end else if (found_q) begin
				res_slot     = hbbc_pkg::SLOT_W'(vict_q);
				res_fill     = 1'b1;
				res_count    = hbbc_pkg::CNT_W'(1);
				wr.wr        = fin_go;
				wr.set_valid = 1'b1;
				wr.retag     = 1'b1;
				wr.mtf       = fin_go;
				wr.idx       = vict_q;
				wr.count     = res_count;
			end else begin
				res_status = hbbc_pkg::ST_NO_FREE;
			end
		end else if (int'(idx_q) >= hbbc_pkg::BUFFERS) begin
			res_slot = idx_q;
		end else begin
			res_slot = idx_q;
			if (act_q == hbbc_pkg::ACT_PIN) begin
				if (rd.count == hbbc_pkg::CNT_MAX) begin
					res_status = hbbc_pkg::ST_SATURATED;
					res_count  = rd.count;
				end else begin
					res_count = rd.count + 1'b1;
				end
			end else begin
				if (rd.count == '0) begin
					res_status = hbbc_pkg::ST_UNDERFLOW;
					res_count  = rd.count;
				end else begin
					res_count = rd.count - 1'b1;
				end
			end
			wr.wr    = fin_go;
			wr.idx   = scan_q;
			wr.count = res_count;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= '0;
			hit_q   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						hit_q   <= 1'b0;
						found_q <= 1'b0;
						if (req.action == hbbc_pkg::ACT_READ) begin
							scan_q  <= '0;
							state_q <= S_SCAN;
						end else begin
							scan_q  <= req.entry_index[hbbc_pkg::IDX_W-1:0];
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						if (better) begin
							found_q <= 1'b1;
						end
						if (scan_q == LAST) begin
							state_q <= S_FIN;
						end else begin
							scan_q <= scan_q + 1'b1;
						end
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and best-victim registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req.action;
			dev_q <= req.device;
			blk_q <= req.block_number;
			idx_q <= req.entry_index;
		end
		if ((state_q == S_SCAN) && !match && better) begin
			vict_q      <= scan_q;
			best_bkt_q  <= rd.bucket;
			best_rank_q <= rd.rank;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			slot_q    <= res_slot;
			hit_out_q <= res_hit;
			fill_q    <= res_fill;
			status_q  <= res_status;
			count_q   <= res_count;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.slot        = slot_q;
	assign rsp.hit         = hit_out_q;
	assign rsp.need_fill   = fill_q;
	assign rsp.status      = status_q;
	assign rsp.count_after = count_q;

`ifndef SYNTH
	// a completed update cycle always presents a result next
	a_fin_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid_q)
		else $error("update cycle did not load the result register");

	// no-free results carry no slot and no count
	a_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == hbbc_pkg::ST_NO_FREE)) |->
		(!hit_out_q && !fill_q && (count_q == '0) && (slot_q == '0)))
		else $error("no-free result with stray fields");

	// a fresh allocation always starts at count one
	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hit_out_q && fill_q) |-> (count_q == hbbc_pkg::CNT_W'(1)))
		else $error("allocated entry with count other than one");

	// no request is taken while an item is in the scanner
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> !$past(accept))
		else $error("request accepted during scan");
`endif

endmodule

@@ design/hbbc_bucket_unit.sv @@
// ----------------------------------------------------------------------------
// hbbc_bucket_unit: block number modulo bucket count
// Value register, then quotient register (times the scaled reciprocal), then
// remainder register (value minus quotient times bucket count) and done.
// ----------------------------------------------------------------------------
module hbbc_bucket_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [hbbc_pkg::BLK_W-1:0]    value,
	output logic                          done,
	output logic [hbbc_pkg::BKT_W-1:0]    rem
);

	logic [hbbc_pkg::BLK_W-1:0]    value_q;
	logic [hbbc_pkg::BLK_W-1:0]    quot_q;
	logic [hbbc_pkg::BKT_W-1:0]    rem_q;
	logic                          mul_q;
	logic                          sub_q;
	logic                          done_q;
	logic [2*hbbc_pkg::BLK_W:0]    prod;
	logic [hbbc_pkg::BLK_W-1:0]    quot;
	logic [hbbc_pkg::BLK_W-1:0]    diff;

	// quotient by reciprocal, remainder by subtraction
	assign prod = (2*hbbc_pkg::BLK_W+1)'(value_q) *
		(2*hbbc_pkg::BLK_W+1)'(hbbc_pkg::BKT_RECIP);
	assign quot = hbbc_pkg::BLK_W'(prod >> hbbc_pkg::BKT_SHIFT);
	assign diff = value_q - quot_q * hbbc_pkg::BLK_W'(hbbc_pkg::BUCKETS);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			sub_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q <= start;
			sub_q <= mul_q;
			if (start) begin
				done_q <= 1'b0;
			end else if (sub_q) begin
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			value_q <= value;
		end
		if (mul_q) begin
			quot_q <= quot;
		end
		if (sub_q) begin
			rem_q <= diff[hbbc_pkg::BKT_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ design/hbbc_entry_table.sv @@
// ----------------------------------------------------------------------------
// hbbc_entry_table: tag, count, valid and rank storage of all entries
// One read address, one entry update and a parallel move-to-front of ranks.
// ----------------------------------------------------------------------------
module hbbc_entry_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hbbc_pkg::IDX_W-1:0]    rd_addr,
	output hbbc_pkg::tbl_rd_t             rd,
	input  hbbc_pkg::tbl_wr_t             wr
);

	logic [hbbc_pkg::DEV_W-1:0] dev_q   [hbbc_pkg::BUFFERS];
	logic [hbbc_pkg::BLK_W-1:0] blk_q   [hbbc_pkg::BUFFERS];
	logic [hbbc_pkg::BKT_W-1:0] bkt_q   [hbbc_pkg::BUFFERS];
	logic [hbbc_pkg::CNT_W-1:0] cnt_q   [hbbc_pkg::BUFFERS];
	logic                       valid_q [hbbc_pkg::BUFFERS];
	logic [hbbc_pkg::IDX_W-1:0] rank_q  [hbbc_pkg::BUFFERS];

	// entry fields and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hbbc_pkg::BUFFERS; i++) begin
				dev_q[i]   <= '0;
				blk_q[i]   <= '0;
				bkt_q[i]   <= '0;
				cnt_q[i]   <= '0;
				valid_q[i] <= 1'b0;
			end
		end else if (wr.wr) begin
			cnt_q[wr.idx] <= wr.count;
			if (wr.set_valid) begin
				valid_q[wr.idx] <= 1'b1;
			end
			if (wr.retag) begin
				dev_q[wr.idx] <= wr.device;
				blk_q[wr.idx] <= wr.block;
				bkt_q[wr.idx] <= wr.bucket;
			end
		end
	end

	// insertion ranks, newest entry moves to rank zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hbbc_pkg::BUFFERS; i++) begin
				rank_q[i] <= hbbc_pkg::IDX_W'(i);
			end
		end else if (wr.mtf) begin
			for (int i = 0; i < hbbc_pkg::BUFFERS; i++) begin
				if (hbbc_pkg::IDX_W'(i) == wr.idx) begin
					rank_q[i] <= '0;
				end else if (rank_q[i] < wr.old_rank) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
		end
	end

	// read port
	assign rd.device = dev_q[rd_addr];
	assign rd.block  = blk_q[rd_addr];
	assign rd.bucket = bkt_q[rd_addr];
	assign rd.count  = cnt_q[rd_addr];
	assign rd.valid  = valid_q[rd_addr];
	assign rd.rank   = rank_q[rd_addr];

endmodule

@@ tb/hbbc_checker.sv @@
// ----------------------------------------------------------------------------
// hbbc_checker: reply checker for the hashed block buffer cache
// Watches the request and reply channels. Every accepted request is run
// through a local copy of the tag table (tags, counts, valid bits, insertion
// ranks), and the reply it should cause is queued. Each accepted reply is
// compared with the oldest queued one.
// ----------------------------------------------------------------------------
module hbbc_checker (
	input  logic clk,
	input  logic arst_n,
	hbbc_req_if  req,
	hbbc_rsp_if  rsp,
	output int   mismatch_count,
	output int   replies_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	import hbbc_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              hit;
		logic              need_fill;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  count_after;
	} cache_reply_t;

	// local copy of the entry table
	logic [DEV_W-1:0] tbl_dev   [BUFFERS];
	logic [BLK_W-1:0] tbl_blk   [BUFFERS];
	logic [CNT_W-1:0] tbl_cnt   [BUFFERS];
	logic             tbl_valid [BUFFERS];
	logic [IDX_W-1:0] tbl_rank  [BUFFERS];

	cache_reply_t owed_replies [$];

	// apply one request to the table copy and return the reply it causes
	function automatic cache_reply_t lookup_and_count(input logic [ACT_W-1:0] act,
			input logic [DEV_W-1:0] dev, input logic [BLK_W-1:0] blk,
			input logic [SLOT_W-1:0] idx);
		cache_reply_t     rep;
		bit               found;
		int               victim;
		int               best_bkt;
		int               best_rank;
		int               bkt;
		logic [IDX_W-1:0] old_rank;
		rep = '0;
		found = 1'b0;
		victim = -1;
		best_bkt = 0;
		best_rank = 0;
		if (act == ACT_READ) begin
			// tag match anywhere, first match wins
			for (int i = 0; i < BUFFERS; i++) begin
				if (!found && tbl_dev[i] == dev && tbl_blk[i] == blk) begin
					found = 1'b1;
					rep.slot = i[SLOT_W-1:0];
					rep.hit = 1'b1;
					rep.need_fill = !tbl_valid[i];
					if (tbl_cnt[i] == CNT_MAX)
						rep.status = ST_SATURATED;
					else
						tbl_cnt[i] = tbl_cnt[i] + 1'b1;
					tbl_valid[i] = 1'b1;
					rep.count_after = tbl_cnt[i];
				end
			end
			if (found)
				return rep;
			// free entry in the lowest bucket, newest insertion first
			for (int i = 0; i < BUFFERS; i++) begin
				if (tbl_cnt[i] == '0) begin
					bkt = int'(tbl_blk[i] % BUCKETS);
					if (victim < 0 || bkt < best_bkt ||
							(bkt == best_bkt && int'(tbl_rank[i]) < best_rank)) begin
						victim = i;
						best_bkt = bkt;
						best_rank = int'(tbl_rank[i]);
					end
				end
			end
			if (victim < 0) begin
				rep.status = ST_NO_FREE;
				return rep;
			end
			tbl_dev[victim] = dev;
			tbl_blk[victim] = blk;
			tbl_cnt[victim] = CNT_W'(1);
			tbl_valid[victim] = 1'b1;
			// move the victim to the front of the insertion order
			old_rank = tbl_rank[victim];
			for (int j = 0; j < BUFFERS; j++) begin
				if (tbl_rank[j] < old_rank)
					tbl_rank[j] = tbl_rank[j] + 1'b1;
			end
			tbl_rank[victim] = '0;
			rep.slot = victim[SLOT_W-1:0];
			rep.need_fill = 1'b1;
			rep.count_after = CNT_W'(1);
			return rep;
		end
		rep.slot = idx;
		if (int'(idx) >= BUFFERS)
			return rep;
		if (act == ACT_PIN) begin
			if (tbl_cnt[idx] == CNT_MAX)
				rep.status = ST_SATURATED;
			else
				tbl_cnt[idx] = tbl_cnt[idx] + 1'b1;
		end else begin
			if (tbl_cnt[idx] == '0)
				rep.status = ST_UNDERFLOW;
			else
				tbl_cnt[idx] = tbl_cnt[idx] - 1'b1;
		end
		rep.count_after = tbl_cnt[idx];
		return rep;
	endfunction

	// table state after reset
	initial begin
		for (int i = 0; i < BUFFERS; i++) begin
			tbl_dev[i] = '0;
			tbl_blk[i] = '0;
			tbl_cnt[i] = '0;
			tbl_valid[i] = 1'b0;
			tbl_rank[i] = i[IDX_W-1:0];
		end
	end

	// compare replies, then predict for the request taken at this edge
	always @(posedge clk) begin
		cache_reply_t got;
		cache_reply_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got.slot = rsp.slot;
				got.hit = rsp.hit;
				got.need_fill = rsp.need_fill;
				got.status = rsp.status;
				got.count_after = rsp.count_after;
				if (owed_replies.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("%0t: reply with none owed", $realtime);
						$display("  got  slot %0d hit %0d fill %0d status %0d count %0d",
							got.slot, got.hit, got.need_fill, got.status,
							got.count_after);
					end
					mismatch_count++;
				end else begin
					want = owed_replies.pop_front();
					if (got !== want) begin
						if (mismatch_count < 10) begin
							$display("%0t: mismatch", $realtime);
							$display("  want slot %0d hit %0d fill %0d status %0d count %0d",
								want.slot, want.hit, want.need_fill, want.status,
								want.count_after);
							$display("  got  slot %0d hit %0d fill %0d status %0d count %0d",
								got.slot, got.hit, got.need_fill, got.status,
								got.count_after);
						end
						mismatch_count++;
					end
				end
			end
			if (req.valid && req.ready)
				owed_replies.push_back(lookup_and_count(req.action, req.device,
					req.block_number, req.entry_index));
		end
		replies_owed = owed_replies.size();
	end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the hashed block buffer cache
// Drives lookups and count updates: a directed opening over the corner cases,
// then random bursts (hot tags, table fills, release sweeps, count hammers)
// under three idling phases. The checker predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hbbc_pkg::*;

	localparam int ITEM_TARGET = 1700;
	localparam int POOL_SIZE   = 20;
	localparam int TIMEOUT_NS  = 1_000_000;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   replies_owed;
	int   items_sent;
	int   send_idle_pct;
	int   recv_idle_pct;

	// hot tags shared by many reads so that hits are common
	logic [DEV_W-1:0] hot_dev [POOL_SIZE];
	logic [BLK_W-1:0] hot_blk [POOL_SIZE];

	hbbc_req_if req_bus ();
	hbbc_rsp_if rsp_bus ();

	hashed_block_buffer_cache u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	hbbc_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_bus),
		.rsp            (rsp_bus),
		.mismatch_count (mismatch_count),
		.replies_owed   (replies_owed)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	// reply side back-pressure, held low during reset
	always @(negedge clk) begin
		if (arst_n)
			rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		else
			rsp_bus.ready <= 1'b0;
	end

	// idling rates follow the progress of the run
	function automatic int idle_phase();
		if (items_sent < ITEM_TARGET / 3)
			return 0;
		if (items_sent < 2 * ITEM_TARGET / 3)
			return 1;
		return 2;
	endfunction

	// offer one item, with a random gap before it, and wait for acceptance
	task automatic send_item(input logic [ACT_W-1:0] act, input logic [DEV_W-1:0] dev,
			input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] idx);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.action <= act;
		req_bus.device <= dev;
		req_bus.block_number <= blk;
		req_bus.entry_index <= idx;
		do
			@(posedge clk);
		while (!req_bus.ready);
		items_sent++;
	endtask

	// unused fields get random values
	task automatic send_read(input logic [DEV_W-1:0] dev, input logic [BLK_W-1:0] blk);
		send_item(ACT_READ, dev, blk, SLOT_W'($urandom));
	endtask

	task automatic send_entry_op(input logic [ACT_W-1:0] act, input logic [SLOT_W-1:0] idx);
		send_item(act, DEV_W'($urandom), $urandom, idx);
	endtask

	// stop offering items until every owed reply has come back
	task automatic hold_until_drained();
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (replies_owed != 0)
			@(negedge clk);
	endtask

	// one release or unpin per entry
	task automatic release_sweep();
		for (int i = 0; i < BUFFERS; i++)
			send_entry_op($urandom_range(1) ? ACT_RELEASE : ACT_UNPIN, i[SLOT_W-1:0]);
	endtask

	// hot-tag reads mixed with count updates on random entries
	task automatic mixed_burst(input int n);
		int pick;
		int k;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			k = $urandom_range(POOL_SIZE - 1);
			if (pick < 40)
				send_read(hot_dev[k], hot_blk[k]);
			else if (pick < 45)
				send_read(DEV_W'($urandom), $urandom);
			else if (pick < 70)
				send_entry_op(ACT_RELEASE, SLOT_W'($urandom));
			else if (pick < 80)
				send_entry_op(ACT_PIN, SLOT_W'($urandom));
			else
				send_entry_op(ACT_UNPIN, SLOT_W'($urandom));
		end
	endtask

	// stimulus
	initial begin
		int  k;
		int  last_phase;
		bit  pin_hammer_done;
		bit  read_hammer_done;
		logic [SLOT_W-1:0] hammer_idx;

		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.action = ACT_READ;
		req_bus.device = '0;
		req_bus.block_number = '0;
		req_bus.entry_index = '0;
		items_sent = 0;
		send_idle_pct = 11;
		recv_idle_pct = 53;
		last_phase = 0;
		pin_hammer_done = 1'b0;
		read_hammer_done = 1'b0;

		// hot tags: bucket neighbors, extremes and random ones
		hot_dev[0] = '0;    hot_blk[0] = '0;
		hot_dev[1] = 8'hFF; hot_blk[1] = 32'hFFFF_FFFF;
		hot_dev[2] = '0;    hot_blk[2] = 32'd13;
		hot_dev[3] = '0;    hot_blk[3] = 32'd26;
		hot_dev[4] = 8'd1;  hot_blk[4] = 32'd12;
		hot_dev[5] = 8'd3;  hot_blk[5] = 32'h8000_0000;
		for (int i = 6; i < POOL_SIZE; i++) begin
			hot_dev[i] = DEV_W'($urandom_range(3));
			hot_blk[i] = $urandom_range(1) ? $urandom_range(60) : $urandom;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset tag hits while never filled, then hits it again once filled
		send_read('0, '0);
		send_read('0, '0);
		// counts down to zero and one past it
		send_entry_op(ACT_RELEASE, 5'd0);
		send_entry_op(ACT_RELEASE, 5'd0);
		send_entry_op(ACT_RELEASE, 5'd0);
		send_entry_op(ACT_UNPIN, 5'd31);
		send_entry_op(ACT_PIN, 5'd31);
		send_entry_op(ACT_UNPIN, 5'd31);
		// misses with extreme and alternating tags, some in the same bucket, and one repeat that hits
		send_read(8'hFF, 32'hFFFF_FFFF);
		send_read(8'hAA, 32'h5555_5555);
		send_read(8'h55, 32'hAAAA_AAAA);
		send_read('0, 32'd13);
		send_read('0, 32'd12);
		send_read(8'd1, '0);
		send_read(8'hFF, 32'hFFFF_FFFF);
		send_read(8'hFE, 32'hFFFF_FFFF);
		send_entry_op(ACT_PIN, 5'd0);
		send_entry_op(ACT_RELEASE, 5'd31);
		send_entry_op(ACT_UNPIN, 5'd21);
		send_entry_op(ACT_RELEASE, 5'd10);
		send_entry_op(ACT_PIN, 5'h15);
		send_entry_op(ACT_UNPIN, 5'h0A);

		// random part
		while (items_sent < ITEM_TARGET) begin
			if (idle_phase() != last_phase) begin
				last_phase = idle_phase();
				hold_until_drained();
				send_idle_pct = (last_phase == 1) ? 53 : 0;
				recv_idle_pct = (last_phase == 1) ? 11 : 0;
			end
			if (!pin_hammer_done && items_sent > 350) begin
				// drive one entry into saturation by pins
				pin_hammer_done = 1'b1;
				hammer_idx = SLOT_W'($urandom);
				repeat (258)
					send_entry_op(ACT_PIN, hammer_idx);
				repeat (3)
					send_entry_op(ACT_UNPIN, hammer_idx);
			end else if (!read_hammer_done && items_sent > 900) begin
				// saturate by repeated hits on one tag, with free entries first
				read_hammer_done = 1'b1;
				release_sweep();
				release_sweep();
				k = $urandom_range(POOL_SIZE - 1);
				repeat (258)
					send_read(hot_dev[k], hot_blk[k]);
			end else begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: begin
						mixed_burst($urandom_range(8, 30));
					end
					6, 7: begin
						// fill the table with fresh tags until it runs out
						repeat ($urandom_range(34, 40))
							send_read(DEV_W'($urandom), $urandom);
						release_sweep();
					end
					default: begin
						release_sweep();
					end
				endcase
			end
		end

		hold_until_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
